/* rtl/core/dmsa_pkg.sv */
// Shared types, codes and constants of the dense matrix scatter-add block.
package dmsa_pkg;

    typedef enum logic [1:0] {
        CMD_ADD_MATRIX = 2'd0,
        CMD_ADD_VECTOR = 2'd1,
        CMD_READ       = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_ADD_MATRIX,
        OP_ADD_VECTOR,
        OP_READ,
        OP_CLEAR,
        OP_REJECT
    } op_kind_t;

    typedef enum logic [2:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_FETCH,
        BK_USE,
        BK_ADD
    } back_state_t;

    localparam int IDX_W = 6;
    localparam int VAL_W = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] DOF_RESET = 7'd64;
    localparam logic [10:0] EXP_MAX = 11'h7FF;
    localparam logic [VAL_W-1:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
    } in_item_t;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] tangent_value;
        logic [VAL_W-1:0] mass_value;
        logic [VAL_W-1:0] residual_value;
        logic [VAL_W-1:0] product_value;
        logic             finite_ok;
    } out_item_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
    } op_t;

    typedef struct packed {
        logic sweeping;
    } back_status_t;

    function automatic logic is_finite(input logic [VAL_W-1:0] v);
        return v[62:52] != EXP_MAX;
    endfunction

endpackage

/* rtl/core/dense_matrix_scatter_add.sv */
// Top level of the dense matrix scatter-add accumulator.
// A rejected or clear transaction yields its result from the idle state, a read after a RAM fetch,
// and a matrix or vector add once the five-stage binary64 adder in the back end is done.
// The back end works on one transaction at a time and returns the results in order.
// After reset and after every clear, a pass over all MAX_DOFS*MAX_DOFS addresses zeroes the stores;
// full stays high during it. Reset sets the DOF register to 64 and the finite flag to one.
module dense_matrix_scatter_add #(
    parameter int MAX_DOFS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  dmsa_pkg::in_item_t         item,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output dmsa_pkg::out_item_t        result,
    input  logic                       cfg_write,
    input  logic [dmsa_pkg::CFG_W-1:0] cfg_data
);

    localparam int OP_W  = $bits(dmsa_pkg::op_t);
    localparam int RES_W = $bits(dmsa_pkg::out_item_t);

    dmsa_pkg::op_t          fr_op, q_op;
    dmsa_pkg::out_item_t    bk_res;
    dmsa_pkg::back_status_t bk_status;
    logic                   fr_push, q_full, q_empty, q_pop, r_push, r_full;
    logic [OP_W-1:0]        q_rdata;
    logic [RES_W-1:0]       r_rdata;

    dmsa_front #(.MAX_DOFS(MAX_DOFS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .bk_status (bk_status),
        .q_push    (fr_push),
        .q_data    (fr_op)
    );

    dmsa_fifo #(.WIDTH(OP_W), .DEPTH(2)) u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .wdata (fr_op),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_op = dmsa_pkg::op_t'(q_rdata);

    dmsa_back #(.MAX_DOFS(MAX_DOFS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (q_empty),
        .op_data  (q_op),
        .op_pop   (q_pop),
        .out_full (r_full),
        .out_push (r_push),
        .out_data (bk_res),
        .status   (bk_status)
    );

    dmsa_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (bk_res),
        .pop   (pop),
        .rdata (r_rdata),
        .full  (r_full),
        .empty (empty)
    );

    assign result = dmsa_pkg::out_item_t'(r_rdata);

endmodule

/* rtl/core/dmsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dmsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dmsa_fifo.sv */
// Small first-in first-out queue built from registers.
module dmsa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/dmsa_fp_add.sv */
// Five-stage binary64 adder with round to nearest even.
module dmsa_fp_add (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] sum
);

    localparam int MW = 56;

    logic [4:0] v_reg;

    logic          a_nan, b_nan, a_inf, b_inf, swap;
    logic [63:0]   x, y;
    logic [10:0]   ex, ey, dx;
    logic [52:0]   mx, my;
    logic [MW-1:0] yfull, ysh, ymask, small0;
    logic          ylost, special0;
    logic [63:0]   spec0;

    logic [MW-1:0] big_s0_reg, small_s0_reg;
    logic          sub_s0_reg, sign_s0_reg, zsign_s0_reg, spec_s0_reg;
    logic [10:0]   exp_s0_reg;
    logic [63:0]   specv_s0_reg;

    logic [MW:0]   sum_s1_reg;
    logic          sign_s1_reg, zsign_s1_reg, spec_s1_reg;
    logic [10:0]   exp_s1_reg;
    logic [63:0]   specv_s1_reg;

    logic [5:0]    lzc;
    logic [MW:0]   sum_s2_reg;
    logic [5:0]    lzc_s2_reg;
    logic          sign_s2_reg, spec_s2_reg;
    logic [10:0]   exp_s2_reg;
    logic [63:0]   specv_s2_reg;

    logic [11:0]   e12, norm_e;
    logic [5:0]    shamt;
    logic [MW-1:0] norm_m;
    logic [MW-1:0] m_s3_reg;
    logic [11:0]   e_s3_reg;
    logic          sign_s3_reg, spec_s3_reg;
    logic [63:0]   specv_s3_reg;

    logic [52:0]   mant53;
    logic          round_up;
    logic [53:0]   m54;
    logic [11:0]   e_fin;
    logic [51:0]   frac_fin;
    logic [63:0]   packed_res;
    logic [63:0]   res_reg;

    always_comb
    begin
        a_nan = (a[62:52] == dmsa_pkg::EXP_MAX) && (a[51:0] != '0);
        b_nan = (b[62:52] == dmsa_pkg::EXP_MAX) && (b[51:0] != '0);
        a_inf = (a[62:52] == dmsa_pkg::EXP_MAX) && (a[51:0] == '0);
        b_inf = (b[62:52] == dmsa_pkg::EXP_MAX) && (b[51:0] == '0);
        special0 = (a[62:52] == dmsa_pkg::EXP_MAX) || (b[62:52] == dmsa_pkg::EXP_MAX);
        if (a_nan || b_nan || (a_inf && b_inf && (a[63] != b[63])))
        begin
            spec0 = dmsa_pkg::CANON_NAN;
        end
        else if (a_inf)
        begin
            spec0 = a;
        end
        else
        begin
            spec0 = b;
        end

        swap = b[62:0] > a[62:0];
        x = swap ? b : a;
        y = swap ? a : b;
        ex = (x[62:52] == '0) ? 11'd1 : x[62:52];
        ey = (y[62:52] == '0) ? 11'd1 : y[62:52];
        mx = {x[62:52] != '0, x[51:0]};
        my = {y[62:52] != '0, y[51:0]};
        dx = ex - ey;
        yfull = {my, 3'b000};
        ysh   = '0;
        ymask = '0;
        ylost = 1'b0;
        if (dx >= 11'(MW))
        begin
            small0 = {{(MW-1){1'b0}}, |my};
        end
        else
        begin
            ysh    = yfull >> dx;
            ymask  = ~({MW{1'b1}} << dx);
            ylost  = |(yfull & ymask);
            small0 = {ysh[MW-1:1], ysh[0] | ylost};
        end
    end

    always_comb
    begin
        lzc = 6'(MW);
        for (int i = 0; i < MW; i++)
        begin
            if (sum_s1_reg[i])
            begin
                lzc = 6'(MW - 1 - i);
            end
        end
    end

    always_comb
    begin
        e12 = {1'b0, exp_s2_reg};
        shamt = '0;
        if (sum_s2_reg[MW])
        begin
            norm_m = {sum_s2_reg[MW:2], sum_s2_reg[1] | sum_s2_reg[0]};
            norm_e = e12 + 12'd1;
        end
        else
        begin
            shamt  = (12'(lzc_s2_reg) <= e12 - 12'd1) ? lzc_s2_reg : 6'(e12 - 12'd1);
            norm_m = sum_s2_reg[MW-1:0] << shamt;
            norm_e = e12 - 12'(shamt);
        end
    end

    always_comb
    begin
        mant53   = m_s3_reg[MW-1:3];
        round_up = m_s3_reg[2] && (m_s3_reg[1] || m_s3_reg[0] || mant53[0]);
        m54      = {1'b0, mant53} + 54'(round_up);
        if (m54[53])
        begin
            e_fin    = e_s3_reg + 12'd1;
            frac_fin = m54[52:1];
        end
        else
        begin
            e_fin    = m54[52] ? e_s3_reg : 12'd0;
            frac_fin = m54[51:0];
        end
        if (spec_s3_reg)
        begin
            packed_res = specv_s3_reg;
        end
        else if (e_fin >= 12'(dmsa_pkg::EXP_MAX))
        begin
            packed_res = {sign_s3_reg, dmsa_pkg::EXP_MAX, 52'd0};
        end
        else
        begin
            packed_res = {sign_s3_reg, e_fin[10:0], frac_fin};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        big_s0_reg   <= {mx, 3'b000};
        small_s0_reg <= small0;
        sub_s0_reg   <= x[63] ^ y[63];
        sign_s0_reg  <= x[63];
        zsign_s0_reg <= x[63] & y[63];
        exp_s0_reg   <= ex;
        spec_s0_reg  <= special0;
        specv_s0_reg <= spec0;

        sum_s1_reg   <= sub_s0_reg ? {1'b0, big_s0_reg} - {1'b0, small_s0_reg}
                                   : {1'b0, big_s0_reg} + {1'b0, small_s0_reg};
        sign_s1_reg  <= sign_s0_reg;
        zsign_s1_reg <= zsign_s0_reg;
        exp_s1_reg   <= exp_s0_reg;
        spec_s1_reg  <= spec_s0_reg;
        specv_s1_reg <= specv_s0_reg;

        sum_s2_reg   <= sum_s1_reg;
        lzc_s2_reg   <= lzc;
        sign_s2_reg  <= (sum_s1_reg == '0) ? zsign_s1_reg : sign_s1_reg;
        exp_s2_reg   <= exp_s1_reg;
        spec_s2_reg  <= spec_s1_reg;
        specv_s2_reg <= specv_s1_reg;

        m_s3_reg     <= norm_m;
        e_s3_reg     <= norm_e;
        sign_s3_reg  <= sign_s2_reg;
        spec_s3_reg  <= spec_s2_reg;
        specv_s3_reg <= specv_s2_reg;

        res_reg      <= packed_res;
    end

    assign done = v_reg[4];
    assign sum  = res_reg;

endmodule

/* rtl/core/dmsa_front.sv */
// Front end: configuration register, input transactions and index checks.
module dmsa_front #(
    parameter int MAX_DOFS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  dmsa_pkg::in_item_t         item,
    output logic                       full,
    input  logic                       cfg_write,
    input  logic [dmsa_pkg::CFG_W-1:0] cfg_data,
    input  logic                       q_full,
    input  dmsa_pkg::back_status_t     bk_status,
    output logic                       q_push,
    output dmsa_pkg::op_t              q_data
);

    logic [dmsa_pkg::CFG_W-1:0] dof_reg;
    logic                       row_ok, col_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dof_reg <= dmsa_pkg::DOF_RESET;
        end
        else if (cfg_write)
        begin
            dof_reg <= cfg_data;
        end
    end

    assign full   = q_full || bk_status.sweeping;
    assign q_push = push && !full;
    assign row_ok = ({1'b0, item.row_index} < dof_reg) && (32'(item.row_index) < 32'(MAX_DOFS));
    assign col_ok = ({1'b0, item.col_index} < dof_reg) && (32'(item.col_index) < 32'(MAX_DOFS));

    always_comb
    begin
        q_data.row          = item.row_index;
        q_data.col          = item.col_index;
        q_data.first_value  = item.first_value;
        q_data.second_value = item.second_value;
        case (item.cmd)
            dmsa_pkg::CMD_ADD_MATRIX:
            begin
                q_data.kind = (row_ok && col_ok) ? dmsa_pkg::OP_ADD_MATRIX : dmsa_pkg::OP_REJECT;
            end
            dmsa_pkg::CMD_ADD_VECTOR:
            begin
                q_data.kind = row_ok ? dmsa_pkg::OP_ADD_VECTOR : dmsa_pkg::OP_REJECT;
            end
            dmsa_pkg::CMD_READ:
            begin
                q_data.kind = (row_ok && col_ok) ? dmsa_pkg::OP_READ : dmsa_pkg::OP_REJECT;
            end
            default:
            begin
                q_data.kind = dmsa_pkg::OP_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/dmsa_back.sv */
// Back end: stores, read-modify-write sequencing and result transactions.
module dmsa_back #(
    parameter int MAX_DOFS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   op_empty,
    input  dmsa_pkg::op_t          op_data,
    output logic                   op_pop,
    input  logic                   out_full,
    output logic                   out_push,
    output dmsa_pkg::out_item_t    out_data,
    output dmsa_pkg::back_status_t status
);

    localparam int MAT_DEPTH = MAX_DOFS * MAX_DOFS;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int VEC_AW    = $clog2(MAX_DOFS);
    localparam int PAIR_W    = 2 * dmsa_pkg::VAL_W;

    dmsa_pkg::back_state_t state_reg, state_next;
    dmsa_pkg::op_t         op_reg;
    logic [MAT_AW-1:0]     sweep_reg, sweep_next;
    logic                  flag_reg, flag_next;

    logic                  take;
    logic [MAT_AW-1:0]     mat_addr, mat_waddr;
    logic [VEC_AW-1:0]     vec_addr, vec_waddr;
    logic                  mat_we, vec_we, mat_re, vec_re;
    logic [PAIR_W-1:0]     mat_wdata, vec_wdata, mat_rdata, vec_rdata;
    logic                  add_start, add1_done, add2_done, add_done;
    logic [63:0]           add1_a, add2_a, sum1, sum2;

    assign take     = (state_reg == dmsa_pkg::BK_IDLE) && !op_empty && !out_full;
    assign mat_addr = MAT_AW'(op_reg.row) * MAT_AW'(MAX_DOFS) + MAT_AW'(op_reg.col);
    assign vec_addr = VEC_AW'(op_reg.row);
    assign add_done = add1_done && add2_done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmsa_pkg::BK_SWEEP:
            begin
                if (sweep_reg == MAT_AW'(MAT_DEPTH - 1))
                begin
                    state_next = dmsa_pkg::BK_IDLE;
                end
            end
            dmsa_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    case (op_data.kind)
                        dmsa_pkg::OP_REJECT: state_next = dmsa_pkg::BK_IDLE;
                        dmsa_pkg::OP_CLEAR:  state_next = dmsa_pkg::BK_SWEEP;
                        default:             state_next = dmsa_pkg::BK_FETCH;
                    endcase
                end
            end
            dmsa_pkg::BK_FETCH:
            begin
                state_next = dmsa_pkg::BK_USE;
            end
            dmsa_pkg::BK_USE:
            begin
                state_next = (op_reg.kind == dmsa_pkg::OP_READ) ? dmsa_pkg::BK_IDLE
                                                                : dmsa_pkg::BK_ADD;
            end
            dmsa_pkg::BK_ADD:
            begin
                if (add_done)
                begin
                    state_next = dmsa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dmsa_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_pop     = take;
        out_push   = 1'b0;
        out_data   = '0;
        flag_next  = flag_reg;
        sweep_next = sweep_reg;
        mat_re     = 1'b0;
        vec_re     = 1'b0;
        mat_we     = 1'b0;
        vec_we     = 1'b0;
        mat_waddr  = mat_addr;
        vec_waddr  = vec_addr;
        mat_wdata  = {sum1, sum2};
        vec_wdata  = {sum1, sum2};
        add_start  = 1'b0;
        add1_a     = mat_rdata[PAIR_W-1:dmsa_pkg::VAL_W];
        add2_a     = mat_rdata[dmsa_pkg::VAL_W-1:0];
        if (op_reg.kind == dmsa_pkg::OP_ADD_VECTOR)
        begin
            add1_a = vec_rdata[PAIR_W-1:dmsa_pkg::VAL_W];
            add2_a = vec_rdata[dmsa_pkg::VAL_W-1:0];
        end
        case (state_reg)
            dmsa_pkg::BK_SWEEP:
            begin
                mat_we     = 1'b1;
                vec_we     = 32'(sweep_reg) < 32'(MAX_DOFS);
                mat_waddr  = sweep_reg;
                vec_waddr  = VEC_AW'(sweep_reg);
                mat_wdata  = '0;
                vec_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
            end
            dmsa_pkg::BK_IDLE:
            begin
                if (take && (op_data.kind == dmsa_pkg::OP_REJECT))
                begin
                    out_push        = 1'b1;
                    out_data.status = 1'b1;
                end
                else if (take && (op_data.kind == dmsa_pkg::OP_CLEAR))
                begin
                    out_push   = 1'b1;
                    flag_next  = 1'b1;
                    sweep_next = '0;
                end
                out_data.finite_ok = flag_next;
            end
            dmsa_pkg::BK_FETCH:
            begin
                mat_re = 1'b1;
                vec_re = 1'b1;
            end
            dmsa_pkg::BK_USE:
            begin
                if (op_reg.kind == dmsa_pkg::OP_READ)
                begin
                    out_push                = 1'b1;
                    out_data.tangent_value  = mat_rdata[PAIR_W-1:dmsa_pkg::VAL_W];
                    out_data.mass_value     = mat_rdata[dmsa_pkg::VAL_W-1:0];
                    out_data.residual_value = vec_rdata[PAIR_W-1:dmsa_pkg::VAL_W];
                    out_data.product_value  = vec_rdata[dmsa_pkg::VAL_W-1:0];
                    out_data.finite_ok      = flag_reg;
                end
                else
                begin
                    add_start = 1'b1;
                end
            end
            dmsa_pkg::BK_ADD:
            begin
                if (add_done)
                begin
                    flag_next = flag_reg && dmsa_pkg::is_finite(sum1)
                                         && dmsa_pkg::is_finite(sum2);
                    out_push  = 1'b1;
                    out_data.finite_ok = flag_next;
                    mat_we    = op_reg.kind == dmsa_pkg::OP_ADD_MATRIX;
                    vec_we    = op_reg.kind == dmsa_pkg::OP_ADD_VECTOR;
                end
            end
            default:
            begin
                op_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmsa_pkg::BK_SWEEP;
            sweep_reg <= '0;
            flag_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= op_data;
        end
    end

    assign status.sweeping = state_reg == dmsa_pkg::BK_SWEEP;

    dmsa_ram #(.WIDTH(PAIR_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .re    (mat_re),
        .raddr (mat_addr),
        .rdata (mat_rdata)
    );

    dmsa_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_DOFS)) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .re    (vec_re),
        .raddr (vec_addr),
        .rdata (vec_rdata)
    );

    dmsa_fp_add u_add_first (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (add1_a),
        .b     (op_reg.first_value),
        .done  (add1_done),
        .sum   (sum1)
    );

    dmsa_fp_add u_add_second (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (add2_a),
        .b     (op_reg.second_value),
        .done  (add2_done),
        .sum   (sum2)
    );

endmodule
